// ----- hw/rtl/nirfd_pkg.sv -----
// Shared constants, types and window function for the NEC IR frame decoder.
package nirfd_pkg;

    // Field widths
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 32;
    localparam int CFG_IDX_W = 3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_START_NOMINAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_NOMINAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_NOMINAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_NOMINAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 3'd4;

    // Register reset values
    localparam logic [COUNT_W-1:0] START_NOMINAL_RST  = 16'd12442;
    localparam logic [COUNT_W-1:0] REPEAT_NOMINAL_RST = 16'd10368;
    localparam logic [COUNT_W-1:0] ZERO_NOMINAL_RST   = 16'd1032;
    localparam logic [COUNT_W-1:0] ONE_NOMINAL_RST    = 16'd2074;
    localparam logic [COUNT_W-1:0] TOLERANCE_RST      = 16'd500;

    // Last data bit position of a frame
    localparam logic [4:0] LAST_BIT = 5'd31;

    // Depth of the queue between classifier and sequencer (2 or more)
    localparam int QUEUE_DEPTH_DEF = 2;

    // Window hits for one interval, as seen by the classifier
    typedef struct packed {
        logic start_hit;
        logic repeat_hit;
        logic zero_hit;
        logic one_hit;
    } t_class;

    // Strict window nom - tol < c < nom + tol, no lower bound when nom <= tol; bounds computed without wrap
    function automatic logic in_window(
        input logic [COUNT_W-1:0] c,
        input logic [COUNT_W-1:0] nom,
        input logic [COUNT_W-1:0] tol
    );
        logic [COUNT_W:0] hi;
        logic             above_low;
        hi        = {1'b0, nom} + {1'b0, tol};
        above_low = (nom <= tol) ? 1'b1 : (c > (nom - tol));
        return above_low && ({1'b0, c} < hi);
    endfunction

endpackage

// ----- hw/rtl/nec_ir_frame_decoder.sv -----
// Top level of the NEC IR frame decoder: classifier, queue and sequencer.
//
// Usage:
//   Input channel (i_valid / o_stall / i_interval_count): one transfer per
//   falling edge of the demodulated IR line, carrying the timer ticks since
//   the previous edge. Output channel (o_valid / i_stall) returns exactly one
//   result per input transfer: frame_valid and repeat_seen pulses plus the
//   current address and key bytes of the frame store.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the five
//   16-bit window registers by index; unknown indexes are ignored. Write only
//   while no item is in flight.
// Timing:
//   A result is offered after its input has passed the queue and the result
//   register. One item per cycle is sustained while i_stall is low.
//   The classifier fills a QUEUE_DEPTH-entry queue; o_stall rises when the
//   queue is full, which happens only while i_stall holds the result.
// Reset:
//   Synchronous active-low i_rst_n returns registers to their defaults,
//   empties the queue, clears the frame store and puts the decoder in idle.
module nec_ir_frame_decoder #(
    parameter int QUEUE_DEPTH = nirfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nirfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nirfd_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [nirfd_pkg::COUNT_W-1:0]      i_interval_count,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_frame_valid,
    output logic                               o_repeat_seen,
    output logic [nirfd_pkg::BYTE_W-1:0]       o_address_byte,
    output logic [nirfd_pkg::BYTE_W-1:0]       o_key_byte
);

    nirfd_pkg::t_class front_class;
    nirfd_pkg::t_class q_head;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;

    // Window classification
    nirfd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_interval_count (i_interval_count),
        .o_class          (front_class)
    );

    // Decoupling queue
    nirfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_class),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    // Frame sequencer and result register
    nirfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_head),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_valid  (o_frame_valid),
        .o_repeat_seen  (o_repeat_seen),
        .o_address_byte (o_address_byte),
        .o_key_byte     (o_key_byte)
    );

endmodule

// ----- hw/rtl/nirfd_front.sv -----
// Front end: configuration registers and per-interval window classification.
module nirfd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [nirfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nirfd_pkg::COUNT_W-1:0]      i_cfg_data,
    input  logic [nirfd_pkg::COUNT_W-1:0]      i_interval_count,
    output nirfd_pkg::t_class                  o_class
);

    logic [nirfd_pkg::COUNT_W-1:0] r_start_nom;
    logic [nirfd_pkg::COUNT_W-1:0] r_repeat_nom;
    logic [nirfd_pkg::COUNT_W-1:0] r_zero_nom;
    logic [nirfd_pkg::COUNT_W-1:0] r_one_nom;
    logic [nirfd_pkg::COUNT_W-1:0] r_tol;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_nom  <= nirfd_pkg::START_NOMINAL_RST;
            r_repeat_nom <= nirfd_pkg::REPEAT_NOMINAL_RST;
            r_zero_nom   <= nirfd_pkg::ZERO_NOMINAL_RST;
            r_one_nom    <= nirfd_pkg::ONE_NOMINAL_RST;
            r_tol        <= nirfd_pkg::TOLERANCE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nirfd_pkg::REG_START_NOMINAL:  r_start_nom  <= i_cfg_data;
                nirfd_pkg::REG_REPEAT_NOMINAL: r_repeat_nom <= i_cfg_data;
                nirfd_pkg::REG_ZERO_NOMINAL:   r_zero_nom   <= i_cfg_data;
                nirfd_pkg::REG_ONE_NOMINAL:    r_one_nom    <= i_cfg_data;
                nirfd_pkg::REG_TOLERANCE:      r_tol        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Four independent window compares; priority is resolved in the back end
    always_comb begin
        o_class.start_hit  = nirfd_pkg::in_window(i_interval_count, r_start_nom, r_tol);
        o_class.repeat_hit = nirfd_pkg::in_window(i_interval_count, r_repeat_nom, r_tol);
        o_class.zero_hit   = nirfd_pkg::in_window(i_interval_count, r_zero_nom, r_tol);
        o_class.one_hit    = nirfd_pkg::in_window(i_interval_count, r_one_nom, r_tol);
    end

endmodule

// ----- hw/rtl/nirfd_queue.sv -----
// Small FIFO of classified intervals between front and back ends.
module nirfd_queue #(
    parameter int DEPTH = nirfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nirfd_pkg::t_class i_data,
    output logic              o_full,
    input  logic              i_pop,
    output nirfd_pkg::t_class o_data,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    nirfd_pkg::t_class r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/nirfd_back.sv -----
// Back end: frame sequencer, bit store, complement check and result register.
module nirfd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  nirfd_pkg::t_class              i_q_data,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_frame_valid,
    output logic                           o_repeat_seen,
    output logic [nirfd_pkg::BYTE_W-1:0]   o_address_byte,
    output logic [nirfd_pkg::BYTE_W-1:0]   o_key_byte
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]                    r_phase;
    logic [1:0]                    n_phase;
    logic [4:0]                    r_bit_index;
    logic [4:0]                    n_bit_index;
    logic [nirfd_pkg::FRAME_W-1:0] r_frame_store;
    logic [nirfd_pkg::FRAME_W-1:0] n_frame_store;
    logic                          n_frame_valid;
    logic                          n_repeat_seen;
    logic                          r_out_valid;
    logic                          out_free;

    // Take the next entry when the result slot is empty or being drained
    assign out_free = !r_out_valid || !i_stall;
    assign o_q_pop  = out_free && !i_q_empty;

    // Sequencer next state
    always_comb begin
        n_phase       = r_phase;
        n_bit_index   = r_bit_index;
        n_frame_store = r_frame_store;
        n_frame_valid = 1'b0;
        n_repeat_seen = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                if (i_q_data.start_hit) begin
                    n_frame_store = '0;
                    n_bit_index   = '0;
                    n_phase       = PH_DATA;
                end else if (i_q_data.repeat_hit) begin
                    n_repeat_seen = 1'b1;
                    n_phase       = PH_IDLE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DATA: begin
                if (i_q_data.zero_hit || i_q_data.one_hit) begin
                    n_frame_store[r_bit_index] = !i_q_data.zero_hit;
                    if (r_bit_index == nirfd_pkg::LAST_BIT) begin
                        n_frame_valid = (n_frame_store[7:0] == ~n_frame_store[15:8]) &&
                                        (n_frame_store[23:16] == ~n_frame_store[31:24]);
                        n_bit_index   = '0;
                        n_phase       = PH_IDLE;
                    end else begin
                        n_bit_index = r_bit_index + 1'b1;
                    end
                end else begin
                    // bad interval: abort, partial store kept
                    n_bit_index = '0;
                    n_phase     = PH_IDLE;
                end
            end
            default: begin
                // idle (and the unused code): the edge only arms the decoder
                n_phase = PH_LEAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_index   <= '0;
            r_frame_store <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase       <= n_phase;
                r_bit_index   <= n_bit_index;
                r_frame_store <= n_frame_store;
            end
            if (out_free) begin
                r_out_valid <= !i_q_empty;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_frame_valid  <= n_frame_valid;
            o_repeat_seen  <= n_repeat_seen;
            o_address_byte <= n_frame_store[7:0];
            o_key_byte     <= n_frame_store[23:16];
        end
    end

    assign o_valid = r_out_valid;

endmodule
